>>> design/rgbe_scanline_rle_decoder_assert.svh
// Assertion macros for the RGBE scanline decoder.
// No dependencies; included by rgbe_rle_back, which checks its own logic.
`ifndef RGBE_SCANLINE_RLE_DECODER_ASSERT_SVH
`define RGBE_SCANLINE_RLE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define RGBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rgbe_rle: assertion failed");
// checked property, also active through reset
`define RGBE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rgbe_rle: assertion failed");
`else
`define RGBE_ASSERT(lbl, clk, rst_n, prop)
`define RGBE_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> design/rgbe_rle_pkg.sv
// Shared types and constants of the RGBE scanline decoder.
// No dependencies; used by every module of the block but rgbe_rle_ram.
package rgbe_rle_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int WIDTH_W       = 13;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_DATA_W    = 16;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WIDTH   = 2'd1;
    localparam logic [1:0] ST_COUNT   = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    // back-end operations
    localparam logic [1:0] OP_NONE  = 2'd0; // status only
    localparam logic [1:0] OP_FILL  = 2'd1; // write count bytes to a plane
    localparam logic [1:0] OP_READ  = 2'd2; // read one pixel from the line store
    localparam logic [1:0] OP_PIXEL = 2'd3; // flat pixel carried in data

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  status;
        logic        eol;
        logic        eoi;
        logic [1:0]  plane;
        logic        restart; // store address starts over at zero
        logic [7:0]  count;
        logic [31:0] data;
    } t_entry;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] exponent;
        logic       pixel_valid;
        logic       end_of_line;
        logic       end_of_image;
        logic [1:0] status;
    } t_result;

endpackage

>>> design/rgbe_rle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbe_rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rgbe_rle_fifo.sv
// Short queue of decoded operations between front and back.
// Depends on rgbe_rle_pkg.
module rgbe_rle_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rgbe_rle_pkg::t_entry  i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output rgbe_rle_pkg::t_entry  o_head,
    output logic                  o_head_valid
);

    localparam int AW = rgbe_rle_pkg::FIFO_AW;

    rgbe_rle_pkg::t_entry r_mem [rgbe_rle_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full       = (r_count == (AW+1)'(rgbe_rle_pkg::FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

endmodule

>>> design/rgbe_rle_front.sv
// Front end: parses each accepted word, tracks scanline/plane/pixel state
// and issues one operation per word to the queue. Depends on rgbe_rle_pkg.
module rgbe_rle_front #(
    parameter int MAX_WIDTH = rgbe_rle_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_cmd,
    input  logic [7:0]                          i_data_byte,
    input  logic [rgbe_rle_pkg::WIDTH_W-1:0]    i_image_width,
    input  logic [rgbe_rle_pkg::HEIGHT_W-1:0]   i_image_height,
    output rgbe_rle_pkg::t_entry                o_entry
);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_PLANES    = 3'd1;
    localparam logic [2:0] PH_DRAIN     = 3'd2;
    localparam logic [2:0] PH_FLAT      = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;
    localparam logic [2:0] PH_ERR_WIDTH = 3'd5;
    localparam logic [2:0] PH_ERR_COUNT = 3'd6;

    localparam logic [1:0] PAIR_COUNT   = 2'd0;
    localparam logic [1:0] PAIR_RUN     = 2'd1;
    localparam logic [1:0] PAIR_LITERAL = 2'd2;

    localparam logic [7:0] RUN_MARK = 8'h80;
    localparam logic [7:0] RUN_BIAS = 8'd128;
    localparam logic [7:0] HDR_MARK = 8'd2;
    localparam int         MIN_RLE  = 8;
    localparam int         WW       = rgbe_rle_pkg::WIDTH_W;
    localparam int         HW       = rgbe_rle_pkg::HEIGHT_W;

    logic [2:0]    r_phase,      n_phase;
    logic [1:0]    r_byte_count, n_byte_count;
    logic [7:0]    r_held [3];
    logic [7:0]    n_held [3];
    logic [1:0]    r_plane,      n_plane;
    logic [WW-1:0] r_pos,        n_pos;
    logic [1:0]    r_pair,       n_pair;
    logic [7:0]    r_bl,         n_bl;
    logic [WW-1:0] r_pix_pos,    n_pix_pos;
    logic [HW-1:0] r_rows,       n_rows;

    logic          eol, eoi, do_pixel, rle_width, rle_head;
    logic [WW-1:0] remaining, pos_new;
    logic [7:0]    run_n;
    rgbe_rle_pkg::t_entry entry;

    assign eol = ({1'b0, r_pix_pos} + (WW+1)'(1)) >= {1'b0, i_image_width};
    assign eoi = eol && (({1'b0, r_rows} + (HW+1)'(1)) >= {1'b0, i_image_height});
    assign remaining = (i_image_width > r_pos) ? (i_image_width - r_pos) : '0;
    assign run_n     = i_data_byte - RUN_BIAS;
    assign rle_width = (i_image_width >= WW'(MIN_RLE))
                    && ({19'd0, i_image_width} <= 32'(MAX_WIDTH));
    assign rle_head  = (r_held[0] == HDR_MARK) && (r_held[1] == HDR_MARK)
                    && !r_held[2][7];

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_held       = r_held;
        n_plane      = r_plane;
        n_pos        = r_pos;
        n_pair       = r_pair;
        n_bl         = r_bl;
        n_pix_pos    = r_pix_pos;
        n_rows       = r_rows;
        pos_new      = r_pos;
        do_pixel     = 1'b0;
        entry        = '0;
        entry.op     = rgbe_rle_pkg::OP_NONE;
        entry.status = rgbe_rle_pkg::ST_OK;

        if (i_accept) begin
            if (r_phase == PH_ERR_WIDTH) begin
                entry.status = rgbe_rle_pkg::ST_WIDTH;
            end else if (r_phase == PH_ERR_COUNT) begin
                entry.status = rgbe_rle_pkg::ST_COUNT;
            end else if (r_phase == PH_DONE) begin
                entry.status = rgbe_rle_pkg::ST_REFUSED;
            end else if (i_cmd) begin
                if (r_phase == PH_DRAIN) begin
                    entry.op      = rgbe_rle_pkg::OP_READ;
                    entry.restart = (r_pix_pos == '0);
                    do_pixel      = 1'b1;
                end else begin
                    entry.status = rgbe_rle_pkg::ST_REFUSED;
                end
            end else if (r_phase == PH_DRAIN) begin
                entry.status = rgbe_rle_pkg::ST_REFUSED;
            end else if (r_phase == PH_PLANES) begin
                if (r_pair == PAIR_COUNT) begin
                    if (i_data_byte > RUN_MARK) begin
                        if ({5'd0, run_n} > remaining) begin
                            n_phase      = PH_ERR_COUNT;
                            entry.status = rgbe_rle_pkg::ST_COUNT;
                        end else begin
                            n_bl   = run_n;
                            n_pair = PAIR_RUN;
                        end
                    end else if (i_data_byte == '0 || {5'd0, i_data_byte} > remaining) begin
                        n_phase      = PH_ERR_COUNT;
                        entry.status = rgbe_rle_pkg::ST_COUNT;
                    end else begin
                        n_bl   = i_data_byte;
                        n_pair = PAIR_LITERAL;
                    end
                end else begin
                    entry.op        = rgbe_rle_pkg::OP_FILL;
                    entry.plane     = r_plane;
                    entry.restart   = (r_pos == '0);
                    entry.data[7:0] = i_data_byte;
                    if (r_pair == PAIR_RUN) begin
                        entry.count = r_bl;
                        pos_new     = r_pos + {5'd0, r_bl};
                        n_bl        = '0;
                        n_pair      = PAIR_COUNT;
                    end else begin
                        entry.count = 8'd1;
                        pos_new     = r_pos + WW'(1);
                        n_bl        = (r_bl != '0) ? (r_bl - 8'd1) : '0;
                        if (n_bl == '0) begin
                            n_pair = PAIR_COUNT;
                        end
                    end
                    n_pos = pos_new;
                    // plane complete: advance plane, or hand the line to drain
                    if (n_pair == PAIR_COUNT && pos_new >= i_image_width) begin
                        n_pos = '0;
                        if (r_plane == 2'd3) begin
                            n_plane   = '0;
                            n_pix_pos = '0;
                            n_phase   = PH_DRAIN;
                        end else begin
                            n_plane = r_plane + 2'd1;
                        end
                    end
                end
            end else begin
                // header or flat: gather four bytes
                if (r_byte_count != 2'd3) begin
                    case (r_byte_count)
                        2'd0:    n_held[0] = i_data_byte;
                        2'd1:    n_held[1] = i_data_byte;
                        default: n_held[2] = i_data_byte;
                    endcase
                    n_byte_count = r_byte_count + 2'd1;
                end else begin
                    n_byte_count = '0;
                    if (r_phase == PH_HEADER && rle_width && rle_head) begin
                        if ({r_held[2], i_data_byte} != {3'd0, i_image_width}) begin
                            n_phase      = PH_ERR_WIDTH;
                            entry.status = rgbe_rle_pkg::ST_WIDTH;
                        end else begin
                            n_plane = '0;
                            n_pos   = '0;
                            n_pair  = PAIR_COUNT;
                            n_bl    = '0;
                            n_phase = PH_PLANES;
                        end
                    end else begin
                        if (r_phase == PH_HEADER) begin
                            n_phase = PH_FLAT;
                        end
                        entry.op   = rgbe_rle_pkg::OP_PIXEL;
                        entry.data = {i_data_byte, r_held[2], r_held[1], r_held[0]};
                        do_pixel   = 1'b1;
                    end
                end
            end
        end

        if (do_pixel) begin
            entry.eol = eol;
            entry.eoi = eoi;
            if (eol) begin
                n_pix_pos = '0;
                n_rows    = r_rows + HW'(1);
            end else begin
                n_pix_pos = r_pix_pos + WW'(1);
            end
            if (eoi) begin
                n_phase = PH_DONE;
            end else if (eol && n_phase == PH_DRAIN) begin
                n_phase = PH_HEADER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_plane      <= '0;
            r_pos        <= '0;
            r_pair       <= PAIR_COUNT;
            r_bl         <= '0;
            r_pix_pos    <= '0;
            r_rows       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_plane      <= n_plane;
            r_pos        <= n_pos;
            r_pair       <= n_pair;
            r_bl         <= n_bl;
            r_pix_pos    <= n_pix_pos;
            r_rows       <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assign o_entry = entry;

endmodule

>>> design/rgbe_rle_back.sv
// Back end: executes queued operations (plane fills, pixel reads) on the
// four-plane line store and registers the output word. Depends on
// rgbe_rle_pkg, rgbe_rle_ram and the assertion macro header.
`include "rgbe_scanline_rle_decoder_assert.svh"
module rgbe_rle_back #(
    parameter int MAX_WIDTH = rgbe_rle_pkg::DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbe_rle_pkg::t_entry  i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rgbe_rle_pkg::t_result o_result
);

    localparam int            AW        = $clog2(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

    logic [AW-1:0] r_waddr, r_raddr;
    logic [7:0]    r_left;
    logic          r_busy;
    logic          r_s1_valid;
    logic          r_out_valid;
    rgbe_rle_pkg::t_entry  r_s1;
    rgbe_rle_pkg::t_result r_out;

    logic          out_ready, s1_ready, step, is_fill, last, we, rd_en;
    logic [7:0]    cur_left;
    logic [AW-1:0] cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
    logic [31:0]   rd_pixel;

    assign out_ready = !r_out_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign step      = i_head_valid && s1_ready;
    assign is_fill   = (i_head.op == rgbe_rle_pkg::OP_FILL);
    assign cur_left  = r_busy ? r_left : i_head.count;
    assign last      = (cur_left <= 8'd1);
    assign cur_waddr = (r_busy || !i_head.restart) ? r_waddr : '0;
    assign cur_raddr = i_head.restart ? '0 : r_raddr;
    assign nxt_waddr = (cur_waddr == LAST_ADDR) ? '0 : (cur_waddr + AW'(1));
    assign nxt_raddr = (cur_raddr == LAST_ADDR) ? '0 : (cur_raddr + AW'(1));

    // a fill stays at the head, one store write per cycle while the output does not stall, until its last byte
    assign we    = step && is_fill;
    assign o_pop = step && (!is_fill || last);
    assign rd_en = o_pop && (i_head.op == rgbe_rle_pkg::OP_READ);

    genvar p;
    generate
        for (p = 0; p < 4; p++) begin : g_plane
            rgbe_rle_ram #(
                .WIDTH (8),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (we && (i_head.plane == 2'(p))),
                .i_waddr (cur_waddr),
                .i_wdata (i_head.data[7:0]),
                .i_re    (rd_en),
                .i_raddr (cur_raddr),
                .o_rdata (rd_pixel[8*p +: 8])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (we) begin
                r_busy <= !last;
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (out_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && out_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_waddr <= nxt_waddr;
            r_left  <= cur_left - 8'd1;
        end
        if (rd_en) begin
            r_raddr <= nxt_raddr;
        end
        if (o_pop) begin
            r_s1 <= i_head;
        end
        if (r_s1_valid && out_ready) begin
            r_out.status       <= r_s1.status;
            r_out.end_of_line  <= r_s1.eol;
            r_out.end_of_image <= r_s1.eoi;
            if (r_s1.op == rgbe_rle_pkg::OP_READ) begin
                r_out.pixel_valid <= 1'b1;
                {r_out.exponent, r_out.blue, r_out.green, r_out.red} <= rd_pixel;
            end else if (r_s1.op == rgbe_rle_pkg::OP_PIXEL) begin
                r_out.pixel_valid <= 1'b1;
                {r_out.exponent, r_out.blue, r_out.green, r_out.red} <= r_s1.data;
            end else begin
                r_out.pixel_valid <= 1'b0;
                {r_out.exponent, r_out.blue, r_out.green, r_out.red} <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // a fill in progress keeps its entry at the queue head
    `RGBE_ASSERT(a_busy_on_fill, i_clk, i_rst_n, r_busy |-> (i_head_valid && is_fill))
    // words without a pixel carry zero pixel fields
    `RGBE_ASSERT(a_nopix_zero, i_clk, i_rst_n, (r_out_valid && !r_out.pixel_valid) |-> ({r_out.red, r_out.green, r_out.blue, r_out.exponent} == '0))
    // a pixel is only ever sent with good status
    `RGBE_ASSERT(a_pix_ok, i_clk, i_rst_n, (r_out_valid && r_out.pixel_valid) |-> (r_out.status == rgbe_rle_pkg::ST_OK))
    // reset empties the back end
    `RGBE_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> (!r_busy && !r_s1_valid && !r_out_valid))

endmodule

>>> design/rgbe_scanline_rle_decoder.sv
// Top level of the RGBE scanline decoder: configuration registers, front
// parser, operation queue and back end. Depends on rgbe_rle_pkg and all
// rgbe_rle_* modules.
//
// Channel     | Dir | tdata (low bit up)                              | tuser / tlast
// ------------+-----+-------------------------------------------------+-------------------
// s_axis      | in  | data_byte[7:0]                                  | tuser: cmd
// m_axis      | out | red, green, blue, exponent, end_of_image, pad   | tuser: pixel_valid,
//             |     |                                                 |  status; tlast: eol
// cfg         | in  | i_cfg_addr 0 = image_width, 1 = image_height    | write only
//
// One input word is taken per cycle while the queue has room and gives exactly
// one output word, through the queue entry, store read stage and output register.
// A run value byte holds the back end while it writes count bytes to the line
// store, one write per cycle while the output does not stall; the four-entry
// queue lets the front keep taking words meanwhile.
// Either side may stall; the output register and read stage hold their word.
// Reset is synchronous, active low; the line store is not cleared and needs
// no clearing pass (entries are always written before a drain reads them).
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = rgbe_rle_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata, // [7:0] data_byte
    input  logic [0:0]                          i_s_axis_tuser, // [0] cmd
    // output words
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] exponent,
    // [32] end_of_image, [39:33] zero
    output logic [39:0]                         o_m_axis_tdata,
    output logic [2:0]                          o_m_axis_tuser, // [0] pixel_valid, [2:1] status
    output logic                                o_m_axis_tlast, // end_of_line
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [rgbe_rle_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [rgbe_rle_pkg::WIDTH_W-1:0]  r_image_width;
    logic [rgbe_rle_pkg::HEIGHT_W-1:0] r_image_height;

    logic                  accept, fifo_full, head_valid, pop;
    rgbe_rle_pkg::t_entry  entry, head;
    rgbe_rle_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rgbe_rle_pkg::WIDTH_W'(1024);
            r_image_height <= rgbe_rle_pkg::HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rgbe_rle_pkg::CFG_IDX_WIDTH:
                    r_image_width  <= i_cfg_wdata[rgbe_rle_pkg::WIDTH_W-1:0];
                rgbe_rle_pkg::CFG_IDX_HEIGHT:
                    r_image_height <= i_cfg_wdata[rgbe_rle_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // the front takes a word whenever the queue has room
    assign o_s_axis_tready = !fifo_full;
    assign accept          = i_s_axis_tvalid && !fifo_full;

    rgbe_rle_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_s_axis_tuser[0]),
        .i_data_byte    (i_s_axis_tdata),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_entry        (entry)
    );

    rgbe_rle_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept),
        .i_entry      (entry),
        .o_full       (fifo_full),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    rgbe_rle_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (result)
    );

    assign o_m_axis_tdata = {7'd0, result.end_of_image, result.exponent,
                             result.blue, result.green, result.red};
    assign o_m_axis_tuser = {result.status, result.pixel_valid};
    assign o_m_axis_tlast = result.end_of_line;

endmodule

>>> test/rgbe_scanline_rle_decoder_tb.sv
// Self-checking testbench for rgbe_scanline_rle_decoder: RLE and flat scanline decode,
// drain and refusal handling, sticky errors. Depends on rgbe_rle_pkg and the decoder RTL.
module rgbe_scanline_rle_decoder_tb;

    localparam int MAXW = rgbe_rle_pkg::DEF_MAX_WIDTH;
    // Cycles with no word accepted on either side before giving up. The slowest
    // correct stretch is a full queue behind a 127-byte run fill plus a receiver
    // hold-off, so this leaves a wide margin.
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 100;
    localparam int WIDE_WIDTH  = 300;

    // predictor state
    typedef enum logic [2:0] {
        DEC_HEADER, DEC_PLANES, DEC_DRAIN, DEC_FLAT, DEC_DONE, DEC_ERR_WIDTH, DEC_ERR_COUNT
    } t_dec_phase;
    typedef enum logic [1:0] {SEG_COUNT, SEG_RUN, SEG_LITERAL} t_seg_phase;

    // directed rows: result typed in only where it is plain (refusals, zero words)
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       typed;
        logic [1:0] st;
    } t_dir_row;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_valid = 1'b0;
    logic [7:0]                          s_data = 8'h00;
    logic [0:0]                          s_cmd = 1'b0;
    logic                                m_ready = 1'b0;
    logic                                cfg_we = 1'b0;
    logic                                cfg_addr = 1'b0;
    logic [rgbe_rle_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                                s_ready;
    logic                                m_valid;
    logic [39:0]                         m_data;
    logic [2:0]                          m_user;
    logic                                m_last;

    // decoder model state
    logic [7:0]  lstore [0:4*MAXW-1];
    logic [7:0]  held [3];
    int unsigned held_n = 0;
    t_dec_phase  dec_phase = DEC_HEADER;
    t_seg_phase  seg = SEG_COUNT;
    int unsigned plane_idx = 0;
    int unsigned plane_pos = 0;
    int unsigned seg_left = 0;
    int unsigned pix_pos = 0;
    int unsigned dec_rows = 0;
    int unsigned cfg_width = 1024;
    int unsigned cfg_height = 1;

    rgbe_rle_pkg::t_result decoded_q [$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned rows_sent = 0;
    int          src_idle = 0;
    int          snk_idle = 0;
    bit          rx_en = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stalled = 0;

    t_dir_row dir_rows [25] = '{
        '{1'b1, 8'h00, 1'b1, rgbe_rle_pkg::ST_REFUSED}, // drain tick with no line stored
        '{1'b0, 8'h02, 1'b1, rgbe_rle_pkg::ST_OK},      // header 2,2,0,8
        '{1'b0, 8'h02, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h00, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h08, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h88, 1'b1, rgbe_rle_pkg::ST_OK},      // red: one run filling the plane
        '{1'b0, 8'hFF, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'hFF, 1'b1, rgbe_rle_pkg::ST_REFUSED}, // drain tick while planes load
        '{1'b0, 8'h01, 1'b1, rgbe_rle_pkg::ST_OK},      // green: literal of one, run of seven
        '{1'b0, 8'h00, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h87, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h80, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h88, 1'b1, rgbe_rle_pkg::ST_OK},      // blue
        '{1'b0, 8'h7F, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'h88, 1'b1, rgbe_rle_pkg::ST_OK},      // exponent; line now stored
        '{1'b0, 8'h01, 1'b1, rgbe_rle_pkg::ST_OK},
        '{1'b0, 8'hA5, 1'b1, rgbe_rle_pkg::ST_REFUSED}, // data word while the line drains
        '{1'b1, 8'h00, 1'b0, rgbe_rle_pkg::ST_OK},      // eight drain ticks, predicted
        '{1'b1, 8'hFF, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'h00, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'h5A, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'h00, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'h00, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'hC3, 1'b0, rgbe_rle_pkg::ST_OK},
        '{1'b1, 8'h00, 1'b0, rgbe_rle_pkg::ST_OK}
    };

    rgbe_scanline_rle_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),  // [7:0] data_byte
        .i_s_axis_tuser  (s_cmd),   // [0] cmd
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),  // red, green, blue, exponent, end_of_image, pad
        .o_m_axis_tuser  (m_user),  // [0] pixel_valid, [2:1] status
        .o_m_axis_tlast  (m_last),  // end_of_line
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Pixel out; advances line/row position and closes the line or the image.
    function automatic rgbe_rle_pkg::t_result emit_pixel(logic [7:0] r, logic [7:0] g,
                                                         logic [7:0] b, logic [7:0] e);
        rgbe_rle_pkg::t_result res;
        logic                  eol;
        logic                  eoi;
        eol = (pix_pos + 1) >= cfg_width;
        eoi = eol && ((dec_rows + 1) >= cfg_height);
        res = '0;
        res.red = r;
        res.green = g;
        res.blue = b;
        res.exponent = e;
        res.pixel_valid = 1'b1;
        res.end_of_line = eol;
        res.end_of_image = eoi;
        res.status = rgbe_rle_pkg::ST_OK;
        if (eol) begin
            pix_pos = 0;
            dec_rows = (dec_rows + 1) & 32'hFFFF;
        end else begin
            pix_pos++;
        end
        if (eoi)
            dec_phase = DEC_DONE;
        else if (eol && dec_phase == DEC_DRAIN)
            dec_phase = DEC_HEADER;
        return res;
    endfunction

    function automatic void put_plane(logic [7:0] v);
        lstore[(plane_idx & 3) * MAXW + (plane_pos % MAXW)] = v;
        plane_pos++;
    endfunction

    // One accepted word in, the one result word it gives out.
    function automatic rgbe_rle_pkg::t_result decode_word(logic cmd, logic [7:0] v);
        rgbe_rle_pkg::t_result res;
        int unsigned           rem;
        int unsigned           n;
        int unsigned           idx;
        logic [15:0]           hdr_w;
        res = '0;
        if (dec_phase == DEC_ERR_WIDTH) begin
            res.status = rgbe_rle_pkg::ST_WIDTH;
        end else if (dec_phase == DEC_ERR_COUNT) begin
            res.status = rgbe_rle_pkg::ST_COUNT;
        end else if (dec_phase == DEC_DONE) begin
            res.status = rgbe_rle_pkg::ST_REFUSED;
        end else if (cmd) begin
            if (dec_phase == DEC_DRAIN) begin
                idx = pix_pos % MAXW;
                res = emit_pixel(lstore[idx], lstore[idx + MAXW], lstore[idx + 2*MAXW],
                                 lstore[idx + 3*MAXW]);
            end else begin
                res.status = rgbe_rle_pkg::ST_REFUSED;
            end
        end else if (dec_phase == DEC_DRAIN) begin
            res.status = rgbe_rle_pkg::ST_REFUSED;
        end else if (dec_phase == DEC_PLANES) begin
            rem = (cfg_width > plane_pos) ? cfg_width - plane_pos : 0;
            if (seg == SEG_COUNT) begin
                // above 0x80 is a run of count-128, else a literal of count bytes
                n = (v > 8'h80) ? int'(v) - 128 : int'(v);
                if (n == 0 || n > rem) begin
                    dec_phase = DEC_ERR_COUNT;
                    res.status = rgbe_rle_pkg::ST_COUNT;
                end else begin
                    seg_left = n;
                    seg = (v > 8'h80) ? SEG_RUN : SEG_LITERAL;
                end
            end else begin
                if (seg == SEG_RUN) begin
                    while (seg_left > 0) begin
                        put_plane(v);
                        seg_left--;
                    end
                    seg = SEG_COUNT;
                end else begin
                    put_plane(v);
                    if (seg_left > 0)
                        seg_left--;
                    if (seg_left == 0)
                        seg = SEG_COUNT;
                end
                if (seg == SEG_COUNT && plane_pos >= cfg_width) begin
                    plane_pos = 0;
                    if (plane_idx >= 3) begin
                        plane_idx = 0;
                        pix_pos = 0;
                        dec_phase = DEC_DRAIN;
                    end else begin
                        plane_idx++;
                    end
                end
            end
        end else if (held_n < 3) begin
            // header or flat pixel: gather four bytes
            held[held_n] = v;
            held_n++;
        end else begin
            held_n = 0;
            if (dec_phase == DEC_HEADER) begin
                if (cfg_width >= 8 && cfg_width <= MAXW && held[0] == 8'h02
                        && held[1] == 8'h02 && !held[2][7]) begin
                    hdr_w = {held[2], v};
                    if (hdr_w != cfg_width) begin
                        dec_phase = DEC_ERR_WIDTH;
                        res.status = rgbe_rle_pkg::ST_WIDTH;
                    end else begin
                        plane_idx = 0;
                        plane_pos = 0;
                        seg = SEG_COUNT;
                        seg_left = 0;
                        dec_phase = DEC_PLANES;
                    end
                end else begin
                    // not an RLE line: header bytes are the first flat pixel
                    dec_phase = DEC_FLAT;
                end
            end
            if (dec_phase == DEC_FLAT)
                res = emit_pixel(held[0], held[1], held[2], v);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < 40)
            $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        rgbe_rle_pkg::t_result want;
        words_checked++;
        if (decoded_q.size() == 0) begin
            flag_mismatch("word with nothing pending", 1, 0);
            return;
        end
        want = decoded_q.pop_front();
        if (m_data[7:0] != want.red)
            flag_mismatch("red", m_data[7:0], want.red);
        if (m_data[15:8] != want.green)
            flag_mismatch("green", m_data[15:8], want.green);
        if (m_data[23:16] != want.blue)
            flag_mismatch("blue", m_data[23:16], want.blue);
        if (m_data[31:24] != want.exponent)
            flag_mismatch("exponent", m_data[31:24], want.exponent);
        if (m_data[32] != want.end_of_image)
            flag_mismatch("end_of_image", m_data[32], want.end_of_image);
        if (m_data[39:33] != 7'd0)
            flag_mismatch("tdata pad", m_data[39:33], 0);
        if (m_user[0] != want.pixel_valid)
            flag_mismatch("pixel_valid", m_user[0], want.pixel_valid);
        if (m_user[2:1] != want.status)
            flag_mismatch("status", m_user[2:1], want.status);
        if (m_last != want.end_of_line)
            flag_mismatch("end_of_line", m_last, want.end_of_line);
    endtask

    // Receiver: checks every accepted word, drives tready (random idling or a
    // long hold-off on request) and runs the watchdog.
    always @(posedge clk) begin
        if (rx_en && m_valid && m_ready)
            check_word();
        if (rx_en) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("rgbe_scanline_rle_decoder_tb failed");
                $finish;
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= rx_en && ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offers one word after a random gap, waits for the handshake, then
    // predicts. Returns at the accepting edge with tvalid still high so a
    // following call can offer back to back.
    task automatic send_word(input logic c, input logic [7:0] d, input logic typed = 1'b0,
                             input logic [1:0] st = rgbe_rle_pkg::ST_OK);
        int                    gap;
        rgbe_rle_pkg::t_result want;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_data <= d;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        want = decode_word(c, d);
        if (typed) begin
            want = '0;
            want.status = st;
        end
        decoded_q = {decoded_q, want};
        words_sent++;
    endtask

    function automatic logic [7:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // now and then a word the decoder must refuse in its current phase
    task automatic send_noise();
        if ($urandom_range(0, 99) < 4) begin
            if (dec_phase == DEC_DRAIN)
                send_word(1'b0, rand_value());
            else
                send_word(1'b1, rand_value());
        end
    endtask

    task automatic send_byte(input logic [7:0] d);
        send_noise();
        send_word(1'b0, d);
    endtask

    task automatic send_tick();
        send_noise();
        send_word(1'b1, rand_value());
    endtask

    // Sender pause: nothing offered until every pending result is back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[rgbe_rle_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rgbe_rle_pkg::CFG_IDX_WIDTH)
            cfg_width = val & 32'h1FFF;
        else
            cfg_height = val & 32'hFFFF;
        @(posedge clk);
    endtask

    function automatic int unsigned pick_width();
        case ($urandom_range(0, 11))
            0: return 8;
            1: return $urandom_range(100, 260);   // lets literals reach 128
            default: return $urandom_range(9, 40);
        endcase
    endfunction

    // One plane as a mix of runs and literals; wide lines use long runs only.
    task automatic encode_plane(input bit wide);
        int unsigned rem;
        int unsigned n;
        int unsigned lim;
        rem = cfg_width;
        while (rem > 0) begin
            if (wide || $urandom_range(0, 1)) begin
                lim = (rem < 127) ? rem : 127;
                n = (wide || $urandom_range(0, 5) == 0) ? lim : $urandom_range(1, lim);
                send_byte(8'(128 + n));
                send_byte(rand_value());
            end else begin
                lim = (rem < 128) ? rem : 128;
                n = ($urandom_range(0, 5) == 0) ? lim : $urandom_range(1, lim);
                send_byte(8'(n));
                repeat (n) send_byte(rand_value());
            end
            rem -= n;
        end
    endtask

    // Header, four planes, then drain ticks until the line is out.
    task automatic send_scanline(input bit wide, input bit hold);
        logic [15:0] w;
        w = cfg_width[15:0];
        send_byte(8'h02);
        send_byte(8'h02);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
        repeat (4) encode_plane(wide);
        if (hold)
            hold_req = 1'b1;    // receiver holds off while ticks keep coming
        while (dec_phase == DEC_DRAIN)
            send_tick();
        rows_sent++;
    endtask

    initial begin
        int unsigned start;
        int unsigned ending;
        int unsigned w;
        int unsigned rem;
        int unsigned n;
        logic [7:0]  hdr [4];
        logic [15:0] bad_w;
        bit          first;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        rx_en <= 1'b1;
        @(posedge clk);

        // directed part: one narrow RLE line with refusals around it
        src_idle = 16;
        snk_idle <= 66;
        write_reg(rgbe_rle_pkg::CFG_IDX_WIDTH, 8);
        write_reg(rgbe_rle_pkg::CFG_IDX_HEIGHT, 16'hFFFF);
        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].st);

        // random RLE lines over three idling profiles; width and height are
        // rewritten between lines once the decoder has gone quiet
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 16 : (ph == 1) ? 66 : 0;
            snk_idle <= (ph == 0) ? 66 : (ph == 1) ? 16 : 0;
            start = words_sent;
            if (ph == 2) begin
                // one wide line with a nonzero header high byte
                settle();
                write_reg(rgbe_rle_pkg::CFG_IDX_WIDTH, WIDE_WIDTH);
                send_scanline(1'b1, 1'b0);
            end
            first = 1'b1;
            while (words_sent - start < 350) begin
                if ($urandom_range(0, 2) == 0) begin
                    settle();
                    write_reg(rgbe_rle_pkg::CFG_IDX_WIDTH, pick_width());
                    if ($urandom_range(0, 3) == 0)
                        write_reg(rgbe_rle_pkg::CFG_IDX_HEIGHT,
                                  $urandom_range(0, 1) ? 16'hFFFF
                                  : dec_rows + $urandom_range(50, 1000));
                end
                send_scanline(1'b0, first && ph < 2);
                first = 1'b0;
            end
        end

        // Ending: every way out is sticky, so one is picked per run.
        settle();
        ending = $urandom_range(0, 2);
        if (ending == 0) begin
            // flat pixels until the image completes, then refused words
            case ($urandom_range(0, 2))
                0: w = 1;
                1: w = $urandom_range(2, 7);
                default: w = $urandom_range(8, 20);
            endcase
            write_reg(rgbe_rle_pkg::CFG_IDX_WIDTH, w);
            write_reg(rgbe_rle_pkg::CFG_IDX_HEIGHT,
                      $urandom_range(0, 1) ? 1 : dec_rows + $urandom_range(1, 2));
            hdr[0] = 8'h02;
            hdr[1] = 8'h02;
            hdr[2] = rand_value();
            hdr[3] = rand_value();
            if (w >= 8) begin
                // width allows RLE, so break the header instead
                n = $urandom_range(0, 2);
                if (n < 2)
                    hdr[n] = hdr[n] ^ 8'(1 << $urandom_range(0, 7));
                else
                    hdr[2][7] = 1'b1;
            end
            foreach (hdr[i])
                send_byte(hdr[i]);
            while (dec_phase != DEC_DONE)
                send_byte(rand_value());
        end else if (ending == 1) begin
            // header width differs from the register
            bad_w = $urandom_range(0, 16'h7FFF);
            if (bad_w == cfg_width)
                bad_w = bad_w ^ 16'h0001;
            send_byte(8'h02);
            send_byte(8'h02);
            send_byte(bad_w[15:8]);
            send_byte(bad_w[7:0]);
        end else begin
            // a few good runs, then a zero or an overlong count
            write_reg(rgbe_rle_pkg::CFG_IDX_WIDTH, $urandom_range(8, 40));
            send_byte(8'h02);
            send_byte(8'h02);
            send_byte(8'h00);
            send_byte(8'(cfg_width));
            rem = cfg_width;
            while (rem > 1 && $urandom_range(0, 1)) begin
                n = $urandom_range(1, rem - 1);
                send_byte(8'(128 + n));
                send_byte(rand_value());
                rem -= n;
            end
            case ($urandom_range(0, 2))
                0: send_byte(8'h00);
                1: send_byte(8'($urandom_range(rem + 1, 128)));
                default: send_byte(8'(128 + $urandom_range(rem + 1, 127)));
            endcase
        end
        repeat (8) send_word(1'($urandom_range(0, 1)), rand_value());

        settle();
        repeat (20) @(posedge clk);
        $display("covered %0d words in, %0d results checked, %0d RLE scanlines",
                 words_sent, words_checked, rows_sent);
        $display("ending: %s", (ending == 0) ? "flat pixels to image end"
                 : (ending == 1) ? "width mismatch" : "bad run count");
        if (mismatches == 0)
            $display("rgbe_scanline_rle_decoder_tb passed");
        else
            $display("rgbe_scanline_rle_decoder_tb failed");
        $finish;
    end

endmodule
